FILE: hdl/itbs_pkg.sv
// Shared types, constants and helper functions for the integer to base string converter.
// Used by the top level integer_to_base_string and by its divider itbs_divider.
// No dependencies.
package itbs_pkg;

   // Field widths of the input and result items.
   localparam int VALUE_BITS = 32;
   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;
   localparam int DIGIT_BITS = 6;

   // Default conversion width, handed to the top level parameter.
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Quotient bits the divider retires per clock cycle.
   localparam int DIV_STEP_BITS = 4;

   // Legal bases.
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

   // ASCII codes.
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_NONE    = 7'h00;

   // Input item.
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0]        radix;
   } itbs_req_type;

   // Result item, one per character.
   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 last_char;
      logic                 bad_radix;
   } itbs_rsp_type;

   // Control from the sequencer to the divider.
   typedef struct packed {
      logic load;
      logic run;
   } itbs_div_ctrl_type;

   // Status from the divider back to the sequencer.
   typedef struct packed {
      logic                  done;
      logic                  quotient_zero;
      logic [DIGIT_BITS-1:0] remainder;
   } itbs_div_status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } itbs_state_type;

   // True when the base lies in the legal range.
   function automatic logic radix_is_valid(input logic [RADIX_BITS-1:0] radix);
      return (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
   endfunction

   // Map a digit value to its ASCII character: '0'-'9', then 'a'-'z'.
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] digit);
      logic [CHAR_BITS-1:0] wide;
      wide = CHAR_BITS'(digit);
      if (digit < 6'd10) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_LOWER_A + wide - 7'd10;
   endfunction

endpackage

FILE: hdl/itbs_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Holds the digits of a conversion for integer_to_base_string.
// No dependencies.
module itbs_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/itbs_divider.sv
// Shared restoring divider for integer_to_base_string: divides by the base DIV_STEP_BITS
// quotient bits per cycle and chains into the next division with the quotient.
// Depends on itbs_pkg.
module itbs_divider #(
   parameter int VALUE_WIDTH = itbs_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  itbs_pkg::itbs_div_ctrl_type         ctrl,
   input  logic [VALUE_WIDTH-1:0]              dividend,
   input  logic [itbs_pkg::RADIX_BITS-1:0]     divisor,
   output itbs_pkg::itbs_div_status_type       status
);

   localparam int STEP    = itbs_pkg::DIV_STEP_BITS;
   localparam int NCHUNK  = (VALUE_WIDTH + STEP - 1) / STEP;
   localparam int DIV_W   = NCHUNK * STEP;
   localparam int CHUNK_W = $clog2(NCHUNK);
   localparam int DB      = itbs_pkg::DIGIT_BITS;

   logic [DIV_W-1:0]                  dividend_ff, dividend_in;
   logic [itbs_pkg::RADIX_BITS-1:0]   divisor_ff, divisor_in;
   logic [DB-1:0]                     rem_ff, rem_in;
   logic [CHUNK_W-1:0]                chunk_ff, chunk_in;

   logic [DB-1:0]    rem_step [STEP+1];
   logic [DB:0]      trial [STEP];
   logic [STEP-1:0]  qbits;
   logic [DIV_W-1:0] shifted;
   logic             last_chunk;

   // DIV_STEP_BITS restoring steps: shift in a dividend bit, subtract the base if it fits.
   always_comb begin
      rem_step[0] = rem_ff;
      for (int j = 0; j < STEP; j++) begin
         trial[j] = {rem_step[j], dividend_ff[DIV_W-1-j]};
         if (trial[j] >= {1'b0, divisor_ff}) begin
            qbits[STEP-1-j] = 1'b1;
            rem_step[j+1]   = DB'(trial[j] - {1'b0, divisor_ff});
         end else begin
            qbits[STEP-1-j] = 1'b0;
            rem_step[j+1]   = trial[j][DB-1:0];
         end
      end
      shifted    = {dividend_ff[DIV_W-STEP-1:0], qbits};
      last_chunk = (chunk_ff == CHUNK_W'(NCHUNK - 1));
   end

   // The shift register fills with quotient bits; after the last chunk it holds
   // the quotient, which is the dividend of the next division.
   always_comb begin
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      chunk_in    = chunk_ff;
      if (ctrl.load) begin
         dividend_in = DIV_W'(dividend);
         divisor_in  = divisor;
         rem_in      = '0;
         chunk_in    = '0;
      end else if (ctrl.run) begin
         dividend_in = shifted;
         rem_in      = last_chunk ? '0 : rem_step[STEP];
         chunk_in    = last_chunk ? '0 : chunk_ff + CHUNK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= '0;
      end else begin
         chunk_ff <= chunk_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   // Status is valid in the cycle that finishes a division.
   assign status.done          = ctrl.run && last_chunk;
   assign status.quotient_zero = (shifted == '0);
   assign status.remainder     = rem_step[STEP];

   // A finished digit is always below the base.
   assert property (@(posedge clock) disable iff (reset)
      status.done |-> (status.remainder < divisor_ff))
      else $error("divider remainder not below the base");

endmodule

FILE: hdl/integer_to_base_string.sv
// Top level of the integer to base string converter: sequencer, digit store and output register.
// Depends on itbs_pkg, itbs_divider and itbs_ram.
//
// An item is taken when start is high and busy is low; busy then stays high until the
// last character has been launched. Characters come out one per cycle on rsp_data,
// most significant first, each marked by rsp_strobe for exactly one cycle, with a
// leading '-' for negative values and last_char on the final one; the receiver must
// take them as they come. A base outside 2 to 36 gives a single result with
// bad_radix set, in the cycle after the item, and the block stays ready. For a legal
// base the time is set by the shared divider, which retires four quotient bits per
// cycle: each digit costs one full division by the base, and the sign step is
// taken whether or not a sign is printed.
module integer_to_base_string #(
   parameter int VALUE_WIDTH = itbs_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  itbs_pkg::itbs_req_type req_data,
   output logic                   rsp_strobe,
   output itbs_pkg::itbs_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(VALUE_WIDTH);
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int DB    = itbs_pkg::DIGIT_BITS;

   itbs_pkg::itbs_state_type      state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   itbs_pkg::itbs_rsp_type        rsp_data_ff, rsp_data_in;

   itbs_pkg::itbs_div_ctrl_type   div_ctrl;
   itbs_pkg::itbs_div_status_type div_status;

   logic                          accept;
   logic                          radix_ok;
   logic [VALUE_WIDTH-1:0]        value_w;
   logic [VALUE_WIDTH-1:0]        magnitude;

   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   logic [DB-1:0]                 ram_wr_data;
   logic [DB-1:0]                 ram_rd_data;

   // Take the low bits of the value as a two's-complement number and form its magnitude.
   assign accept    = start && (state_ff == itbs_pkg::ST_IDLE);
   assign radix_ok  = itbs_pkg::radix_is_valid(req_data.radix);
   assign value_w   = VALUE_WIDTH'($unsigned(req_data.value));
   assign magnitude = value_w[VALUE_WIDTH-1] ? (~value_w + VALUE_WIDTH'(1)) : value_w;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itbs_pkg::ST_IDLE: begin
            if (accept && radix_ok) begin
               state_in = itbs_pkg::ST_DIVIDE;
            end
         end
         itbs_pkg::ST_DIVIDE: begin
            if (div_status.done && div_status.quotient_zero) begin
               state_in = itbs_pkg::ST_SIGN;
            end
         end
         itbs_pkg::ST_SIGN: begin
            state_in = itbs_pkg::ST_EMIT;
         end
         itbs_pkg::ST_EMIT: begin
            if (idx_ff == '0) begin
               state_in = itbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itbs_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control and result formation.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      neg_in        = neg_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '{out_char: itbs_pkg::CHAR_NONE, last_char: 1'b0, bad_radix: 1'b0};
      div_ctrl      = '{load: 1'b0, run: 1'b0};
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IDX_W-1:0];
      ram_wr_data   = div_status.remainder;
      unique case (state_ff)
         itbs_pkg::ST_IDLE: begin
            if (accept) begin
               if (radix_ok) begin
                  div_ctrl.load = 1'b1;
                  neg_in        = value_w[VALUE_WIDTH-1];
                  count_in      = '0;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{out_char: itbs_pkg::CHAR_NONE, last_char: 1'b1,
                                    bad_radix: 1'b1};
               end
            end
         end
         itbs_pkg::ST_DIVIDE: begin
            // Each finished division stores one digit, least significant first.
            div_ctrl.run = 1'b1;
            if (div_status.done) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               idx_in    = count_ff[IDX_W-1:0];
            end
         end
         itbs_pkg::ST_SIGN: begin
            // The read of the top digit is under way; launch the sign if needed.
            rsp_strobe_in = neg_ff;
            rsp_data_in   = '{out_char: itbs_pkg::CHAR_MINUS, last_char: 1'b0,
                              bad_radix: 1'b0};
         end
         itbs_pkg::ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{out_char: itbs_pkg::digit_char(ram_rd_data),
                              last_char: (idx_ff == '0), bad_radix: 1'b0};
            if (idx_ff != '0) begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itbs_pkg::ST_IDLE;
         count_ff      <= '0;
         neg_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         neg_ff        <= neg_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Shared divider.
   itbs_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (magnitude),
      .divisor  (req_data.radix),
      .status   (div_status)
   );

   // Digit store; the read address follows the next index so data lines up in ST_EMIT.
   itbs_ram #(
      .WIDTH (DB),
      .DEPTH (VALUE_WIDTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   assign busy       = (state_ff != itbs_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // An item with a bad base answers with a flagged result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !radix_ok) |=> (rsp_strobe && rsp_data.bad_radix))
      else $error("bad base did not produce a flagged result");

   // The final character leaves the block ready for the next item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_char) |-> !busy)
      else $error("still busy on the final character");

   // Characters of one number come out in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_char) |=> rsp_strobe)
      else $error("gap inside a character string");

endmodule
